FILE: rtl/gawe_pkg.sv
// ----------------------------------------------------------------------------
// gawe_pkg
// Shared types and codes for the graph adjacency walk engine.
// ----------------------------------------------------------------------------
package gawe_pkg;

    // Fixed field widths of the item and result ports
    localparam int VID_W   = 5;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int VCOUNT_W = 6;

    typedef logic [VID_W-1:0]  vid_t;
    typedef logic [OP_W-1:0]   op_t;
    typedef logic [STAT_W-1:0] stat_t;

    // Operation codes; the two unused codes fall to the default arm
    localparam op_t OP_ADD_VERTEX = 3'd0;
    localparam op_t OP_REM_VERTEX = 3'd1;
    localparam op_t OP_ADD_EDGE   = 3'd2;
    localparam op_t OP_REM_EDGE   = 3'd3;
    localparam op_t OP_BFS        = 3'd4;
    localparam op_t OP_DFS        = 3'd5;
    localparam op_t OP_SPARE_6    = 3'd6;
    localparam op_t OP_SPARE_7    = 3'd7;

    // Result status codes
    localparam stat_t ST_OK   = 2'd0;
    localparam stat_t ST_BAD  = 2'd1;
    localparam stat_t ST_FULL = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_EDGE2,
        S_FILT,
        S_BPOP,
        S_BCUR,
        S_BSCAN,
        S_DTOP,
        S_DPOP,
        S_DNB
    } state_t;

endpackage

FILE: rtl/gawe_ram.sv
// ----------------------------------------------------------------------------
// gawe_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gawe_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 5
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/gawe_seq.sv
// ----------------------------------------------------------------------------
// gawe_seq
// Operation sequencer: vertex flags, list lengths, walk control and results.
// Neighbor lists and the walk queue/stack live in external RAMs.
// ----------------------------------------------------------------------------
module gawe_seq #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_DEGREE   = 8,
    parameter int ST_AW        = 8,
    parameter int SC_AW        = 5,
    parameter int SC_DW        = 9
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  gawe_pkg::op_t           opcode,
    input  gawe_pkg::vid_t          vertex_a,
    input  gawe_pkg::vid_t          vertex_b,
    output logic                    busy,
    output logic                    result_valid,
    output gawe_pkg::vid_t          visit_vertex,
    output logic                    is_last,
    output gawe_pkg::stat_t         status,
    output logic [gawe_pkg::VCOUNT_W-1:0] vertex_count,
    // neighbor store RAM
    output logic                    st_we,
    output logic [ST_AW-1:0]        st_waddr,
    output gawe_pkg::vid_t          st_wdata,
    output logic [ST_AW-1:0]        st_raddr,
    input  gawe_pkg::vid_t          st_rdata,
    // walk queue / stack RAM
    output logic                    sc_we,
    output logic [SC_AW-1:0]        sc_waddr,
    output logic [SC_DW-1:0]        sc_wdata,
    output logic [SC_AW-1:0]        sc_raddr,
    input  logic [SC_DW-1:0]        sc_rdata
);

    import gawe_pkg::*;

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_DEGREE + 1);
    localparam int SW  = $clog2(MAX_VERTICES + 1);

    // Flat neighbor-store address of entry j of list v
    function automatic logic [ST_AW-1:0] st_addr(input logic [VIW-1:0] v,
                                                 input logic [CW-1:0] j);
        logic [ST_AW-1:0] base;
        base = ST_AW'(ST_AW'(v) * ST_AW'(MAX_DEGREE));
        return ST_AW'(base + ST_AW'(j));
    endfunction

    state_t state_reg, state_next;

    op_t              op_reg, op_next;
    vid_t             a_reg, a_next;
    vid_t             b_reg, b_next;
    vid_t             key_reg, key_next;
    logic [VIW-1:0]   fv_reg, fv_next;
    logic             all_reg, all_next;
    logic             second_reg, second_next;
    logic [CW-1:0]    rj_reg, rj_next;
    logic [CW-1:0]    wj_reg, wj_next;
    logic             drop_reg, drop_next;
    logic             pr_reg, pr_next;
    vid_t             cur_reg, cur_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [SW-1:0]    head_reg, head_next;
    logic [SW-1:0]    tail_reg, tail_next;
    logic [SW-1:0]    sp_reg, sp_next;
    vid_t             pend_reg, pend_next;
    logic             hasp_reg, hasp_next;
    logic [MAX_VERTICES-1:0] pres_reg, pres_next;
    logic [MAX_VERTICES-1:0] vis_reg, vis_next;
    logic [CW-1:0]    cnt_reg [MAX_VERTICES];
    logic [CW-1:0]    cnt_next [MAX_VERTICES];
    logic [SW-1:0]    total_reg, total_next;

    logic             rv_reg, rv_next;
    vid_t             vv_reg, vv_next;
    logic             last_reg, last_next;
    stat_t            stat_reg, stat_next;
    logic [VCOUNT_W-1:0] vc_reg, vc_next;

    // Shared decode of the current item and list state
    logic           a_in, b_in, pa, pb, bad_ends;
    logic [VIW-1:0] ia, ib, icur, iw;
    logic [CW-1:0]  cnt_a, cnt_b, n_f, n_c;
    logic           filt_issue, filt_done, scan_issue, scan_done;
    logic           w_new, b_take, d_take;

    assign a_in  = int'(a_reg) < MAX_VERTICES;
    assign b_in  = int'(b_reg) < MAX_VERTICES;
    assign ia    = VIW'(a_reg);
    assign ib    = VIW'(b_reg);
    assign icur  = VIW'(cur_reg);
    assign iw    = VIW'(st_rdata);
    assign pa    = a_in && pres_reg[ia];
    assign pb    = b_in && pres_reg[ib];
    assign bad_ends = !pa || !pb || (a_reg == b_reg);
    assign cnt_a = cnt_reg[ia];
    assign cnt_b = cnt_reg[ib];
    assign n_f   = cnt_reg[fv_reg];
    assign n_c   = cnt_reg[icur];

    assign filt_issue = rj_reg < n_f;
    assign filt_done  = !pr_reg && !filt_issue;
    assign scan_issue = rj_reg < n_c;
    assign scan_done  = !pr_reg && !scan_issue;

    assign w_new  = (int'(st_rdata) < MAX_VERTICES) && !vis_reg[iw];
    assign b_take = w_new && (int'(tail_reg) < MAX_VERTICES);
    assign d_take = w_new && (int'(sp_reg) < MAX_VERTICES);

    assign busy = (state_reg != S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (op_reg)
                    OP_REM_VERTEX: if (pa) state_next = S_FILT;
                    OP_ADD_EDGE:
                    begin
                        if (!bad_ends && int'(cnt_a) < MAX_DEGREE
                            && int'(cnt_b) < MAX_DEGREE)
                        begin
                            state_next = S_EDGE2;
                        end
                    end
                    OP_REM_EDGE:   if (!bad_ends) state_next = S_FILT;
                    OP_BFS:        if (pa) state_next = S_BPOP;
                    OP_DFS:        if (pa) state_next = S_DTOP;
                    default:       state_next = S_IDLE;
                endcase
            end
            S_EDGE2: state_next = S_IDLE;
            S_FILT:
            begin
                if (filt_done)
                begin
                    if (all_reg ? (int'(fv_reg) == MAX_VERTICES - 1) : second_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_BPOP:  state_next = (head_reg == tail_reg) ? S_IDLE : S_BCUR;
            S_BCUR:  state_next = S_BSCAN;
            S_BSCAN: if (scan_done) state_next = S_BPOP;
            S_DTOP:
            begin
                if (pos_reg >= n_c)
                begin
                    state_next = (sp_reg == SW'(1)) ? S_IDLE : S_DPOP;
                end
                else
                begin
                    state_next = S_DNB;
                end
            end
            S_DPOP:  state_next = S_DTOP;
            S_DNB:   state_next = S_DTOP;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM ports and results
    always_comb
    begin
        logic  em;
        vid_t  em_vis;
        logic  em_last;
        stat_t em_st;
        logic  vis_do;
        vid_t  vis_id;

        em = 1'b0; em_vis = '0; em_last = 1'b1; em_st = ST_OK;
        vis_do = 1'b0; vis_id = '0;

        op_next = op_reg; a_next = a_reg; b_next = b_reg; key_next = key_reg;
        fv_next = fv_reg; all_next = all_reg; second_next = second_reg;
        rj_next = rj_reg; wj_next = wj_reg; drop_next = drop_reg; pr_next = pr_reg;
        cur_next = cur_reg; pos_next = pos_reg;
        head_next = head_reg; tail_next = tail_reg; sp_next = sp_reg;
        pend_next = pend_reg; hasp_next = hasp_reg;
        pres_next = pres_reg; vis_next = vis_reg; total_next = total_reg;
        cnt_next = cnt_reg;

        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
        sc_we = 1'b0; sc_waddr = '0; sc_wdata = '0; sc_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode;
                    a_next  = vertex_a;
                    b_next  = vertex_b;
                end
            end
            S_EXEC:
            begin
                rj_next = '0; wj_next = '0; drop_next = 1'b0; pr_next = 1'b0;
                case (op_reg)
                    OP_ADD_VERTEX:
                    begin
                        em = 1'b1;
                        if (!a_in)
                        begin
                            em_st = ST_BAD;
                        end
                        else if (!pres_reg[ia])
                        begin
                            pres_next[ia] = 1'b1;
                            cnt_next[ia]  = '0;
                            total_next    = SW'(total_reg + 1'b1);
                        end
                    end
                    OP_REM_VERTEX:
                    begin
                        if (!pa)
                        begin
                            em = 1'b1;
                        end
                        fv_next = '0; key_next = a_reg;
                        all_next = 1'b1; second_next = 1'b0;
                    end
                    OP_ADD_EDGE:
                    begin
                        if (bad_ends)
                        begin
                            em = 1'b1; em_st = ST_BAD;
                        end
                        else if (int'(cnt_a) >= MAX_DEGREE || int'(cnt_b) >= MAX_DEGREE)
                        begin
                            em = 1'b1; em_st = ST_FULL;
                        end
                        else
                        begin
                            st_we = 1'b1;
                            st_waddr = st_addr(ia, cnt_a);
                            st_wdata = b_reg;
                            cnt_next[ia] = CW'(cnt_a + 1'b1);
                        end
                    end
                    OP_REM_EDGE:
                    begin
                        if (bad_ends)
                        begin
                            em = 1'b1; em_st = ST_BAD;
                        end
                        fv_next = ia; key_next = b_reg;
                        all_next = 1'b0; second_next = 1'b0;
                    end
                    OP_BFS:
                    begin
                        if (!pa)
                        begin
                            em = 1'b1; em_st = ST_BAD;
                        end
                        else
                        begin
                            vis_next = '0;
                            vis_next[ia] = 1'b1;
                            sc_we = 1'b1;
                            sc_waddr = '0;
                            sc_wdata = {a_reg, CW'(0)};
                            head_next = '0;
                            tail_next = SW'(1);
                            hasp_next = 1'b0;
                        end
                    end
                    OP_DFS:
                    begin
                        if (!pa)
                        begin
                            em = 1'b1; em_st = ST_BAD;
                        end
                        else
                        begin
                            vis_next = '0;
                            vis_next[ia] = 1'b1;
                            pend_next = a_reg;
                            hasp_next = 1'b1;
                            cur_next = a_reg;
                            pos_next = '0;
                            sp_next = SW'(1);
                        end
                    end
                    default:
                    begin
                        em = 1'b1;
                    end
                endcase
            end
            // second half of an edge insert
            S_EDGE2:
            begin
                st_we = 1'b1;
                st_waddr = st_addr(ib, cnt_b);
                st_wdata = a_reg;
                cnt_next[ib] = CW'(cnt_b + 1'b1);
                em = 1'b1;
            end
            // compact one list, dropping the key (first match or all matches)
            S_FILT:
            begin
                if (filt_issue)
                begin
                    st_raddr = st_addr(fv_reg, rj_reg);
                    rj_next = CW'(rj_reg + 1'b1);
                end
                pr_next = filt_issue;
                if (pr_reg)
                begin
                    if (st_rdata == key_reg && (all_reg || !drop_reg))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        st_we = 1'b1;
                        st_waddr = st_addr(fv_reg, wj_reg);
                        st_wdata = st_rdata;
                        wj_next = CW'(wj_reg + 1'b1);
                    end
                end
                if (filt_done)
                begin
                    cnt_next[fv_reg] = wj_reg;
                    rj_next = '0; wj_next = '0; drop_next = 1'b0; pr_next = 1'b0;
                    if (all_reg)
                    begin
                        if (int'(fv_reg) == MAX_VERTICES - 1)
                        begin
                            cnt_next[ia]  = '0;
                            pres_next[ia] = 1'b0;
                            total_next    = SW'(total_reg - 1'b1);
                            em = 1'b1;
                        end
                        else
                        begin
                            fv_next = VIW'(fv_reg + 1'b1);
                        end
                    end
                    else if (!second_reg)
                    begin
                        fv_next = ib; key_next = a_reg; second_next = 1'b1;
                    end
                    else
                    begin
                        em = 1'b1;
                    end
                end
            end
            // breadth walk: dequeue
            S_BPOP:
            begin
                if (head_reg == tail_reg)
                begin
                    em = 1'b1; em_vis = pend_reg;
                end
                else
                begin
                    sc_raddr = SC_AW'(head_reg);
                    head_next = SW'(head_reg + 1'b1);
                end
            end
            S_BCUR:
            begin
                cur_next = sc_rdata[SC_DW-1:CW];
                vis_do = 1'b1;
                vis_id = sc_rdata[SC_DW-1:CW];
                rj_next = '0;
                pr_next = 1'b0;
            end
            // breadth walk: queue unmarked neighbors
            S_BSCAN:
            begin
                if (scan_issue)
                begin
                    st_raddr = st_addr(icur, rj_reg);
                    rj_next = CW'(rj_reg + 1'b1);
                end
                pr_next = scan_issue;
                if (pr_reg && b_take)
                begin
                    vis_next[iw] = 1'b1;
                    sc_we = 1'b1;
                    sc_waddr = SC_AW'(tail_reg);
                    sc_wdata = {st_rdata, CW'(0)};
                    tail_next = SW'(tail_reg + 1'b1);
                end
            end
            // depth walk: advance or backtrack
            S_DTOP:
            begin
                if (pos_reg >= n_c)
                begin
                    if (sp_reg == SW'(1))
                    begin
                        em = 1'b1; em_vis = pend_reg;
                    end
                    else
                    begin
                        sc_raddr = SC_AW'(sp_reg - SW'(2));
                        sp_next = SW'(sp_reg - 1'b1);
                    end
                end
                else
                begin
                    st_raddr = st_addr(icur, pos_reg);
                    pos_next = CW'(pos_reg + 1'b1);
                end
            end
            S_DPOP:
            begin
                cur_next = sc_rdata[SC_DW-1:CW];
                pos_next = sc_rdata[CW-1:0];
            end
            S_DNB:
            begin
                if (d_take)
                begin
                    vis_next[iw] = 1'b1;
                    vis_do = 1'b1;
                    vis_id = st_rdata;
                    sc_we = 1'b1;
                    sc_waddr = SC_AW'(sp_reg - 1'b1);
                    sc_wdata = {cur_reg, pos_reg};
                    cur_next = st_rdata;
                    pos_next = '0;
                    sp_next = SW'(sp_reg + 1'b1);
                end
            end
            default:
            begin
            end
        endcase

        // A visit releases the previous one, now known not to be last
        if (vis_do)
        begin
            if (hasp_reg)
            begin
                em = 1'b1; em_vis = pend_reg; em_last = 1'b0;
            end
            pend_next = vis_id;
            hasp_next = 1'b1;
        end

        rv_next   = em;
        vv_next   = em ? em_vis : vv_reg;
        last_next = em ? em_last : last_reg;
        stat_next = em ? em_st : stat_reg;
        vc_next   = em ? VCOUNT_W'(total_next) : vc_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pres_reg  <= '0;
            total_reg <= '0;
            rv_reg    <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pres_reg  <= pres_next;
            total_reg <= total_next;
            rv_reg    <= rv_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next; a_reg <= a_next; b_reg <= b_next; key_reg <= key_next;
        fv_reg <= fv_next; all_reg <= all_next; second_reg <= second_next;
        rj_reg <= rj_next; wj_reg <= wj_next; drop_reg <= drop_next; pr_reg <= pr_next;
        cur_reg <= cur_next; pos_reg <= pos_next;
        head_reg <= head_next; tail_reg <= tail_next; sp_reg <= sp_next;
        pend_reg <= pend_next; hasp_reg <= hasp_next; vis_reg <= vis_next;
        vv_reg <= vv_next; last_reg <= last_next; stat_reg <= stat_next;
        vc_reg <= vc_next;
    end

    assign result_valid = rv_reg;
    assign visit_vertex = vv_reg;
    assign is_last      = last_reg;
    assign status       = stat_reg;
    assign vertex_count = vc_reg;

endmodule

FILE: rtl/graph_adjacency_walk_engine.sv
// Add edge writes both lists; remove edge compacts both lists; remove vertex compacts every
// list in turn. One item in flight; the next is taken as busy drops; results never stall.
// Reset clears vertex flags, list lengths and control; RAM contents are kept.
// ----------------------------------------------------------------------------
// graph_adjacency_walk_engine
// Undirected graph store with breadth and depth walks over adjacency lists.
// ----------------------------------------------------------------------------
module graph_adjacency_walk_engine #(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_DEGREE   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gawe_pkg::op_t                 opcode,
    input  gawe_pkg::vid_t                vertex_a,
    input  gawe_pkg::vid_t                vertex_b,
    output logic                          result_valid,
    output gawe_pkg::vid_t                visit_vertex,
    output logic                          is_last,
    output gawe_pkg::stat_t               status,
    output logic [gawe_pkg::VCOUNT_W-1:0] vertex_count
);

    import gawe_pkg::*;

    localparam int ST_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int SC_AW    = $clog2(MAX_VERTICES);
    localparam int SC_DW    = VID_W + $clog2(MAX_DEGREE + 1);

    logic             st_we;
    logic [ST_AW-1:0] st_waddr, st_raddr;
    vid_t             st_wdata, st_rdata;
    logic             sc_we;
    logic [SC_AW-1:0] sc_waddr, sc_raddr;
    logic [SC_DW-1:0] sc_wdata, sc_rdata;

    // Sequencer
    gawe_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .ST_AW        (ST_AW),
        .SC_AW        (SC_AW),
        .SC_DW        (SC_DW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .busy         (busy),
        .result_valid (result_valid),
        .visit_vertex (visit_vertex),
        .is_last      (is_last),
        .status       (status),
        .vertex_count (vertex_count),
        .st_we        (st_we),
        .st_waddr     (st_waddr),
        .st_wdata     (st_wdata),
        .st_raddr     (st_raddr),
        .st_rdata     (st_rdata),
        .sc_we        (sc_we),
        .sc_waddr     (sc_waddr),
        .sc_wdata     (sc_wdata),
        .sc_raddr     (sc_raddr),
        .sc_rdata     (sc_rdata)
    );

    // Neighbor lists, MAX_DEGREE slots per vertex
    gawe_ram #(
        .DEPTH (ST_DEPTH),
        .WIDTH (VID_W)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // BFS queue / DFS stack of {vertex, position}
    gawe_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (SC_DW)
    ) u_scratch (
        .clk   (clk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (sc_raddr),
        .rdata (sc_rdata)
    );

endmodule

FILE: rtl/gawe_chk.sv
// ----------------------------------------------------------------------------
// gawe_chk
// Port-level checks for the graph adjacency walk engine.
// ----------------------------------------------------------------------------
module gawe_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  gawe_pkg::op_t                 opcode,
    input  gawe_pkg::vid_t                vertex_a,
    input  gawe_pkg::vid_t                vertex_b,
    input  logic                          result_valid,
    input  gawe_pkg::vid_t                visit_vertex,
    input  logic                          is_last,
    input  gawe_pkg::stat_t               status,
    input  logic [gawe_pkg::VCOUNT_W-1:0] vertex_count
);

    import gawe_pkg::*;

    // An accepted item keeps the engine busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // The engine goes idle exactly as the final result appears
    a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && is_last)
        else $error("busy dropped without a final result");

    // A non-final walk result means more results are still to come
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_last |-> busy)
        else $error("intermediate result while idle");

    // Errors are single final results with no visited vertex
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_BAD || status == ST_FULL)
            |-> is_last && visit_vertex == '0)
        else $error("error result malformed");

endmodule

bind graph_adjacency_walk_engine gawe_chk u_gawe_chk (.*);

FILE: tb/graph_walk_checker.sv
// ----------------------------------------------------------------------------
// graph_walk_checker
// Watches the command and result channels of the walk engine, keeps its own
// copy of the graph, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module graph_walk_checker
    import gawe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  op_t        opcode,
    input  vid_t       vertex_a,
    input  vid_t       vertex_b,
    input  logic       result_valid,
    input  vid_t       visit_vertex,
    input  logic       is_last,
    input  stat_t      status,
    input  logic [5:0] vertex_count,
    output int         fail_count,
    output int         pending,
    output int         walks_seen,
    output int         results_seen
);

    localparam int NV  = 32;
    localparam int DEG = 8;

    typedef struct packed {
        vid_t       vis;
        logic       last;
        stat_t      st;
        logic [5:0] cnt;
    } walk_result_t;

    // graph mirror
    logic       present_q [NV];
    int         deg_q     [NV];
    vid_t       adj_q     [NV][DEG];
    int         total_q;
    walk_result_t expected_q [$];

    function automatic void drop_at(int v, int k);
        for (int i = k; i + 1 < deg_q[v]; i++) adj_q[v][i] = adj_q[v][i+1];
        deg_q[v]--;
    endfunction

    function automatic void drop_first_of(int v, int w);
        for (int i = 0; i < deg_q[v]; i++)
            if (adj_q[v][i] == w) begin
                drop_at(v, i);
                return;
            end
    endfunction

    function automatic void push_visit(int v);
        walk_result_t r;
        r.vis = vid_t'(v); r.last = 1'b0; r.st = ST_OK; r.cnt = 6'(total_q);
        expected_q = {expected_q, r};
    endfunction

    function automatic void walk_breadth(int s);
        logic seen [NV];
        int q [$];
        int cur;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[s] = 1'b1;
        q = {q, s};
        while (q.size() > 0) begin
            cur = q.pop_front();
            push_visit(cur);
            for (int i = 0; i < deg_q[cur]; i++)
                if (!seen[adj_q[cur][i]]) begin
                    seen[adj_q[cur][i]] = 1'b1;
                    q = {q, int'(adj_q[cur][i])};
                end
        end
    endfunction

    function automatic void walk_depth(int s);
        logic seen [NV];
        int sv [$];
        int sp [$];
        int cur, pos, w;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[s] = 1'b1;
        push_visit(s);
        sv = {sv, s}; sp = {sp, 0};
        while (sv.size() > 0) begin
            cur = sv[$];
            pos = sp[$];
            if (pos >= deg_q[cur]) begin
                void'(sv.pop_back()); void'(sp.pop_back());
            end else begin
                sp[$] = pos + 1;
                w = adj_q[cur][pos];
                if (!seen[w]) begin
                    seen[w] = 1'b1;
                    push_visit(w);
                    sv = {sv, w}; sp = {sp, 0};
                end
            end
        end
    endfunction

    // apply one command to the mirror and queue its expected results
    function automatic void predict_command(op_t op, int a, int b);
        walk_result_t r;
        stat_t st;
        int i;
        st = ST_OK;
        case (op)
            OP_ADD_VERTEX:
                if (!present_q[a]) begin
                    present_q[a] = 1'b1; deg_q[a] = 0; total_q++;
                end
            OP_REM_VERTEX:
                if (present_q[a]) begin
                    for (int v = 0; v < NV; v++) begin
                        i = 0;
                        while (i < deg_q[v])
                            if (adj_q[v][i] == a) drop_at(v, i);
                            else i++;
                    end
                    deg_q[a] = 0; present_q[a] = 1'b0; total_q--;
                end
            OP_ADD_EDGE:
                if (!present_q[a] || !present_q[b] || a == b) st = ST_BAD;
                else if (deg_q[a] >= DEG || deg_q[b] >= DEG) st = ST_FULL;
                else begin
                    adj_q[a][deg_q[a]] = vid_t'(b); deg_q[a]++;
                    adj_q[b][deg_q[b]] = vid_t'(a); deg_q[b]++;
                end
            OP_REM_EDGE:
                if (!present_q[a] || !present_q[b] || a == b) st = ST_BAD;
                else begin
                    drop_first_of(a, b);
                    drop_first_of(b, a);
                end
            OP_BFS, OP_DFS:
                if (!present_q[a]) st = ST_BAD;
                else begin
                    if (op == OP_BFS) walk_breadth(a);
                    else walk_depth(a);
                    expected_q[$].last = 1'b1;
                    walks_seen++;
                    return;
                end
            default: ;
        endcase
        r.vis = '0; r.last = 1'b1; r.st = st; r.cnt = 6'(total_q);
        expected_q = {expected_q, r};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t e;
        if (!rst_n)
        begin
            foreach (present_q[i]) begin present_q[i] = 1'b0; deg_q[i] = 0; end
            total_q = 0;
            fail_count = 0;
            walks_seen = 0;
            results_seen = 0;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            // result channel
            if (result_valid)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: vis=%0d last=%0b st=%0d cnt=%0d",
                                 visit_vertex, is_last, status, vertex_count);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.vis !== visit_vertex || e.last !== is_last ||
                        e.st !== status || e.cnt !== vertex_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp vis=%0d last=%0b st=%0d cnt=%0d, %s%0d %0b %0d %0d",
                                     e.vis, e.last, e.st, e.cnt, "got ",
                                     visit_vertex, is_last, status, vertex_count);
                    end
                end
            end
            // command channel
            if (start && !busy)
                predict_command(opcode, vertex_a, vertex_b);
            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/tb_graph_adjacency_walk_engine.sv
// ----------------------------------------------------------------------------
// tb_graph_adjacency_walk_engine
// Drives graph build, teardown and walk commands into the engine with random
// sender gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_graph_adjacency_walk_engine;
    import gawe_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    op_t        opcode;
    vid_t       vertex_a;
    vid_t       vertex_b;
    logic       result_valid;
    vid_t       visit_vertex;
    logic       is_last;
    stat_t      status;
    logic [5:0] vertex_count;
    int         fail_count;
    int         pending;
    int         walks_seen;
    int         results_seen;
    int         idle_pct;
    int         quiet_cycles = 0;
    int         items_sent;

    localparam int WATCHDOG = 20000;

    graph_adjacency_walk_engine dut (.*);

    graph_walk_checker chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog on cycles without any accepted item or result
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("watchdog expired");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // hold one command until accepted, with random gaps before it
    task automatic send_command(op_t op, int a, int b);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        vertex_a <= vid_t'(a);
        vertex_b <= vid_t'(b);
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
    endtask

    // mostly graph-shaped commands over a small vertex pool, some noise
    task automatic send_random(int pool);
        int r;
        r = $urandom_range(99);
        if (r < 22)      send_command(OP_ADD_VERTEX, $urandom_range(pool), 0);
        else if (r < 50) send_command(OP_ADD_EDGE, $urandom_range(pool), $urandom_range(pool));
        else if (r < 58) send_command(OP_REM_EDGE, $urandom_range(pool), $urandom_range(pool));
        else if (r < 64) send_command(OP_REM_VERTEX, $urandom_range(pool), 0);
        else if (r < 78) send_command(OP_BFS, $urandom_range(pool), 0);
        else if (r < 92) send_command(OP_DFS, $urandom_range(pool), 0);
        else send_command(op_t'($urandom_range(7)), $urandom_range(31), $urandom_range(31));
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_ADD_VERTEX;
        vertex_a = '0;
        vertex_b = '0;
        items_sent = 0;
        idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors on empty graph, extremes, full lists, unused codes
        send_command(OP_BFS, 0, 0);
        send_command(OP_DFS, 31, 0);
        send_command(OP_REM_VERTEX, 5, 0);
        send_command(OP_ADD_VERTEX, 0, 0);
        send_command(OP_ADD_VERTEX, 31, 0);
        send_command(OP_ADD_VERTEX, 31, 0);
        send_command(OP_ADD_EDGE, 0, 0);
        send_command(OP_ADD_EDGE, 0, 7);
        for (int i = 1; i <= 9; i++)
        begin
            send_command(OP_ADD_VERTEX, i, 0);
            send_command(OP_ADD_EDGE, 0, i);
        end
        send_command(OP_ADD_EDGE, 0, 31);
        send_command(OP_ADD_EDGE, 1, 2);
        send_command(OP_ADD_EDGE, 1, 2);
        send_command(OP_BFS, 0, 0);
        send_command(OP_DFS, 31, 0);
        send_command(OP_REM_EDGE, 3, 4);
        send_command(OP_REM_EDGE, 2, 1);
        send_command(OP_REM_EDGE, 9, 9);
        send_command(OP_SPARE_6, 31, 31);
        send_command(OP_SPARE_7, 0, 0);
        send_command(OP_REM_VERTEX, 0, 0);
        send_command(OP_DFS, 1, 0);

        // random phases: sender idles 28%, then 67%, then never
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 28 : (ph == 1) ? 67 : 0;
            for (int k = 0; k < 48; k++)
                send_random((k % 20 < 15) ? 11 : 31);
        end

        // drain
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d items, %0d walks, %0d results checked",
                 items_sent, walks_seen, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
